### hdl/assert_macros.svh
// Assertion shorthands, clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pidc_pkg.sv
package pidc_pkg;

	localparam int DataW     = 32;              // Q16.16 values and bias, Q8.24 gains
	localparam int TimeW     = 24;              // Q8.16 time step
	localparam int FracW     = 16;
	localparam int GainFracW = 24;
	localparam int IntW      = 48;              // Q32.16 integral and derivative
	localparam int GainW     = 32;
	localparam int MulBW     = TimeW + 1;       // signed B operand of the multiplier
	localparam int ProdW     = GainW + MulBW;
	localparam int AccW      = 58;              // output sum before clamping
	localparam int DvdW      = DataW + 1 + FracW;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int EffWMin         = 16;
	localparam int EffWMax         = 32;

	localparam logic [DataW-1:0] GainPReset = 32'd3355443;
	localparam logic [DataW-1:0] GainIReset = 32'd83886;
	localparam logic [DataW-1:0] GainDReset = 32'd1677722;
	localparam logic [DataW-1:0] BiasReset  = 32'd0;

	typedef enum logic [1:0] {
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D,
		CFG_BIAS
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_ACC,
		ST_DIV_WAIT,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_INT,
		OP_KP_LO,
		OP_KP_HI,
		OP_KI_LO,
		OP_KI_HI,
		OP_KD_LO,
		OP_KD_HI
	} mul_op_t;

	typedef struct packed {
		logic signed [DataW-1:0] measured_value;
		logic signed [DataW-1:0] setpoint;
		logic        [TimeW-1:0] time_step;
	} pidc_in_t;

	typedef struct packed {
		logic signed [DataW-1:0] drive;
		logic                    zero_step_flag;
		logic                    saturated_flag;
	} pidc_out_t;

endpackage

### hdl/pid_controller_step.sv
// PID controller, one control step per input beat.
//
// Input channel (in_valid/in_ready/in_item): measured value, setpoint and
// time step. Output channel (out_valid/out_ready/out_item): saturated drive
// plus zero-step and saturation flags, exactly one result beat per input beat.
// The user must write gains and bias via cfg_wr_en/cfg_index/cfg_data only while idle; unenforced.
//
// The step time is set by the 49-step restoring divider for the derivative,
// which is not started when the time step is zero. in_ready comes back the
// cycle after the result is loaded. The seven gain and integral products go
// through one shared 32x25 multiplier, each through the ST_MUL and ST_ACC
// states, mostly hidden under the division.
//
// Reset clears the integral and the previous error and loads the default
// gains. A finished result sits in the output register; a new beat may be
// taken while it waits, but the next result is held back until out_ready
// frees that register.
`include "assert_macros.svh"

module pid_controller_step #(
	parameter int VALUE_WIDTH = pidc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pidc_pkg::pidc_in_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pidc_pkg::pidc_out_t              out_item,
	input  logic                             cfg_wr_en,
	input  logic [1:0]                       cfg_index,
	input  logic [pidc_pkg::DataW-1:0]       cfg_data
);

	localparam int DataW = pidc_pkg::DataW;
	localparam int TimeW = pidc_pkg::TimeW;
	localparam int FracW = pidc_pkg::FracW;
	localparam int GFrac = pidc_pkg::GainFracW;
	localparam int IntW  = pidc_pkg::IntW;
	localparam int MulBW = pidc_pkg::MulBW;
	localparam int ProdW = pidc_pkg::ProdW;
	localparam int AccW  = pidc_pkg::AccW;
	localparam int DvdW  = pidc_pkg::DvdW;

	// working width of error and drive, held to 16..32 bits
	localparam int EffW = (VALUE_WIDTH < pidc_pkg::EffWMin) ? pidc_pkg::EffWMin :
		((VALUE_WIDTH > pidc_pkg::EffWMax) ? pidc_pkg::EffWMax : VALUE_WIDTH);

	localparam logic [DataW-1:0] ClampMax = DataW'((64'd1 << (EffW - 1)) - 64'd1);
	localparam logic [DataW-1:0] ClampMin = ~ClampMax;

	pidc_pkg::state_t  state_q, state_d;
	pidc_pkg::mul_op_t op_q, op_next;

	// registers
	logic [DataW-1:0] gain_p_q, gain_i_q, gain_d_q, bias_q;

	// controller state
	logic [IntW-1:0]  integ_q;
	logic [DataW-1:0] prev_q;

	// per-step working registers
	logic [DataW-1:0]        err_q;
	logic [TimeW-1:0]        dt_q;
	logic                    zero_q;
	logic                    sat_q;
	logic                    neg_q;
	logic [IntW-1:0]         deriv_q;
	logic signed [ProdW-1:0] mul_q;
	logic [AccW-1:0]         acc_q;
	pidc_pkg::pidc_out_t     out_item_q;
	logic                    out_valid_q;

	// strobes from the sequencer
	logic accept, div_start, out_load;

	// error path
	logic [DataW:0]   err_diff;
	logic             err_hit;
	logic [DataW-1:0] err_val;

	// derivative dividend
	logic [DataW:0] dd;
	logic [DataW:0] dd_mag;

	// shared multiplier operands
	logic [IntW-1:0]         op_v;
	logic signed [DataW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;

	// integral update
	logic [IntW:0]   int_sum;
	logic            int_hit;
	logic [IntW-1:0] int_val;

	// derivative clamp
	logic            div_busy;
	logic [DvdW-1:0] div_quot;
	logic            dq_hit_pos, dq_hit_neg;
	logic [IntW-1:0] deriv_val;

	// output clamp
	logic [AccW-EffW:0] acc_top;
	logic               drv_hit;
	logic [DataW-1:0]   drv_val;

	//------------------------------------------------------------------
	// error = measured - setpoint, clamped to the working width
	assign err_diff = {in_item.measured_value[DataW-1], in_item.measured_value}
		- {in_item.setpoint[DataW-1], in_item.setpoint};
	assign err_hit  = !((&err_diff[DataW:EffW-1]) || !(|err_diff[DataW:EffW-1]));
	assign err_val  = err_hit ? (err_diff[DataW] ? ClampMin : ClampMax) : err_diff[DataW-1:0];

	// error minus previous error, magnitude scaled by 2^16 for the divider
	assign dd     = {err_q[DataW-1], err_q} - {prev_q[DataW-1], prev_q};
	assign dd_mag = dd[DataW] ? (~dd + 1'b1) : dd;

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({dd_mag, {FracW{1'b0}}}),
		.divisor  (dt_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// quotient truncates toward zero; clamp to signed 48 bits after the sign
	assign dq_hit_pos = |div_quot[DvdW-1:IntW-1];
	assign dq_hit_neg = div_quot[DvdW-1] | (div_quot[IntW-1] & (|div_quot[IntW-2:0]));
	always_comb begin
		if (neg_q) begin
			deriv_val = dq_hit_neg ? {1'b1, {(IntW-1){1'b0}}} : (~div_quot[IntW-1:0] + 1'b1);
		end else begin
			deriv_val = dq_hit_pos ? {1'b0, {(IntW-1){1'b1}}} : div_quot[IntW-1:0];
		end
	end

	//------------------------------------------------------------------
	// Shared multiplier. A gain times a 48-bit operand is done in two halves:
	// gain*hi counts in full, floor(gain*lo / 2^24) is added to it.
	always_comb begin
		op_v  = '0;
		mul_a = '0;
		mul_b = '0;
		case (op_q) inside
			pidc_pkg::OP_INT: begin
				mul_a = prev_q;
				mul_b = {1'b0, dt_q};
			end
			pidc_pkg::OP_KP_LO, pidc_pkg::OP_KP_HI: begin
				op_v  = {{(IntW-DataW){err_q[DataW-1]}}, err_q};
				mul_a = gain_p_q;
			end
			pidc_pkg::OP_KI_LO, pidc_pkg::OP_KI_HI: begin
				op_v  = integ_q;
				mul_a = gain_i_q;
			end
			pidc_pkg::OP_KD_LO, pidc_pkg::OP_KD_HI: begin
				op_v  = deriv_q;
				mul_a = gain_d_q;
			end
			default: begin
				op_v  = '0;
				mul_a = '0;
			end
		endcase
		case (op_q) inside
			pidc_pkg::OP_KP_LO, pidc_pkg::OP_KI_LO, pidc_pkg::OP_KD_LO:
				mul_b = {1'b0, op_v[GFrac-1:0]};
			pidc_pkg::OP_KP_HI, pidc_pkg::OP_KI_HI, pidc_pkg::OP_KD_HI:
				mul_b = {op_v[IntW-1], op_v[IntW-1:GFrac]};
			default:
				mul_b = {1'b0, dt_q};
		endcase
	end

	// integral += floor(prev_error * dt / 2^16), saturating at 48 bits
	assign int_sum = {integ_q[IntW-1], integ_q}
		+ {{(IntW+1-(ProdW-FracW)){mul_q[ProdW-1]}}, mul_q[ProdW-1:FracW]};
	assign int_hit = int_sum[IntW] ^ int_sum[IntW-1];
	assign int_val = int_hit ? (int_sum[IntW] ? {1'b1, {(IntW-1){1'b0}}}
		: {1'b0, {(IntW-1){1'b1}}}) : int_sum[IntW-1:0];

	// drive clamp to the working width
	assign acc_top = acc_q[AccW-1:EffW-1];
	assign drv_hit = !((&acc_top) || !(|acc_top));
	assign drv_val = drv_hit ? (acc_q[AccW-1] ? ClampMin : ClampMax) : acc_q[DataW-1:0];

	//------------------------------------------------------------------
	// sequencer
	always_comb begin
		case (op_q)
			pidc_pkg::OP_INT:   op_next = pidc_pkg::OP_KP_LO;
			pidc_pkg::OP_KP_LO: op_next = pidc_pkg::OP_KP_HI;
			pidc_pkg::OP_KP_HI: op_next = pidc_pkg::OP_KI_LO;
			pidc_pkg::OP_KI_LO: op_next = pidc_pkg::OP_KI_HI;
			pidc_pkg::OP_KI_HI: op_next = pidc_pkg::OP_KD_LO;
			pidc_pkg::OP_KD_LO: op_next = pidc_pkg::OP_KD_HI;
			default:            op_next = pidc_pkg::OP_INT;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pidc_pkg::ST_IDLE:
				if (in_valid) begin
					state_d = pidc_pkg::ST_LOAD;
				end
			pidc_pkg::ST_LOAD:
				state_d = pidc_pkg::ST_MUL;
			pidc_pkg::ST_MUL:
				state_d = pidc_pkg::ST_ACC;
			pidc_pkg::ST_ACC:
				if (op_q == pidc_pkg::OP_KD_HI) begin
					state_d = pidc_pkg::ST_FIN;
				end else if (op_q == pidc_pkg::OP_KI_HI) begin
					state_d = pidc_pkg::ST_DIV_WAIT;
				end else begin
					state_d = pidc_pkg::ST_MUL;
				end
			pidc_pkg::ST_DIV_WAIT:
				if (!div_busy) begin
					state_d = pidc_pkg::ST_MUL;
				end
			pidc_pkg::ST_FIN:
				if (!out_valid_q || out_ready) begin
					state_d = pidc_pkg::ST_IDLE;
				end
			default:
				state_d = pidc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			pidc_pkg::ST_IDLE: in_ready  = 1'b1;
			pidc_pkg::ST_LOAD: div_start = !zero_q;
			pidc_pkg::ST_FIN:  out_load  = !out_valid_q || out_ready;
			default: begin
				in_ready  = 1'b0;
				div_start = 1'b0;
				out_load  = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	//------------------------------------------------------------------
	// control, registers and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidc_pkg::ST_IDLE;
			op_q        <= pidc_pkg::OP_INT;
			out_valid_q <= 1'b0;
			gain_p_q    <= pidc_pkg::GainPReset;
			gain_i_q    <= pidc_pkg::GainIReset;
			gain_d_q    <= pidc_pkg::GainDReset;
			bias_q      <= pidc_pkg::BiasReset;
			integ_q     <= '0;
			prev_q      <= '0;
		end else begin
			state_q <= state_d;

			if (state_q == pidc_pkg::ST_LOAD) begin
				op_q <= pidc_pkg::OP_INT;
			end else if (state_q == pidc_pkg::ST_ACC) begin
				op_q <= op_next;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					pidc_pkg::CFG_GAIN_P: gain_p_q <= cfg_data;
					pidc_pkg::CFG_GAIN_I: gain_i_q <= cfg_data;
					pidc_pkg::CFG_GAIN_D: gain_d_q <= cfg_data;
					pidc_pkg::CFG_BIAS:   bias_q   <= cfg_data;
					default:              bias_q   <= bias_q;
				endcase
			end

			if (state_q == pidc_pkg::ST_ACC && op_q == pidc_pkg::OP_INT) begin
				integ_q <= int_val;
			end

			// error becomes the previous error once its result is out
			if (out_load) begin
				prev_q <= err_q;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= err_val;
			dt_q   <= in_item.time_step;
			zero_q <= in_item.time_step == '0;
		end

		if (state_q == pidc_pkg::ST_LOAD) begin
			acc_q   <= {{(AccW-DataW){bias_q[DataW-1]}}, bias_q};
			sat_q   <= 1'b0;
			neg_q   <= dd[DataW];
			deriv_q <= '0;
		end

		if (state_q == pidc_pkg::ST_MUL) begin
			mul_q <= mul_a * mul_b;
		end

		if (state_q == pidc_pkg::ST_ACC) begin
			case (op_q) inside
				pidc_pkg::OP_INT:
					sat_q <= int_hit;
				pidc_pkg::OP_KP_LO, pidc_pkg::OP_KI_LO, pidc_pkg::OP_KD_LO:
					acc_q <= acc_q + {{(AccW-(ProdW-GFrac)){mul_q[ProdW-1]}},
						mul_q[ProdW-1:GFrac]};
				pidc_pkg::OP_KP_HI, pidc_pkg::OP_KI_HI, pidc_pkg::OP_KD_HI:
					acc_q <= acc_q + {{(AccW-ProdW){mul_q[ProdW-1]}}, mul_q};
				default:
					acc_q <= acc_q;
			endcase
		end

		if (state_q == pidc_pkg::ST_DIV_WAIT && !div_busy && !zero_q) begin
			deriv_q <= deriv_val;
		end

		if (out_load) begin
			out_item_q.drive          <= drv_val;
			out_item_q.zero_step_flag <= zero_q;
			out_item_q.saturated_flag <= sat_q | drv_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	//------------------------------------------------------------------
	`ASSERT_NEXT(a_accept_starts_step, in_valid && in_ready,
		!in_ready && state_q == pidc_pkg::ST_LOAD, "step did not start after accept")
	`ASSERT_SAME(a_div_within_step, div_busy,
		state_q == pidc_pkg::ST_MUL || state_q == pidc_pkg::ST_ACC || state_q == pidc_pkg::ST_DIV_WAIT,
		"divider running outside a step")
	`ASSERT_SAME(a_deriv_ready, state_q == pidc_pkg::ST_MUL && (op_q == pidc_pkg::OP_KD_LO || op_q == pidc_pkg::OP_KD_HI),
		!div_busy, "derivative product issued before quotient")
	`ASSERT_SAME(a_drive_in_range, out_valid,
		(&out_item.drive[DataW-1:EffW-1]) || !(|out_item.drive[DataW-1:EffW-1]),
		"drive outside working width")

endmodule

### hdl/pidc_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module pidc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pidc_pkg::DvdW-1:0]  dividend,
	input  logic [pidc_pkg::TimeW-1:0] divisor,
	output logic                       busy,
	output logic [pidc_pkg::DvdW-1:0]  quotient
);

	localparam int DvdW = pidc_pkg::DvdW;
	localparam int DvsW = pidc_pkg::TimeW;
	localparam int CntW = $clog2(DvdW + 1);

	logic [CntW-1:0] cnt_q;
	logic [DvdW-1:0] dvd_q;     // dividend shifts out, quotient shifts in
	logic [DvsW-1:0] rem_q;
	logic [DvsW-1:0] dvs_q;
	logic [DvsW:0]   rem_w;
	logic [DvsW:0]   rem_d;
	logic            fits;

	assign rem_w    = {rem_q, dvd_q[DvdW-1]};
	assign rem_d    = rem_w - {1'b0, dvs_q};
	assign fits     = rem_w >= {1'b0, dvs_q};
	assign busy     = cnt_q != '0;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(DvdW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? rem_d[DvsW-1:0] : rem_w[DvsW-1:0];
			dvd_q <= {dvd_q[DvdW-2:0], fits};
		end
	end

endmodule
